FILE: design/psc_pkg.sv
package psc_pkg;

	localparam int RawW    = 20;
	localparam int TempW   = 24;
	localparam int WordW   = 32;
	localparam int CfgIdxW = 8;
	localparam int CfgDatW = 64;
	localparam int CoefW   = 16;

	localparam logic [WordW-1:0] TempOfs    = 32'd64000;
	localparam logic [WordW-1:0] PressBase  = 32'd1048576;
	localparam logic [WordW-1:0] PressScale = 32'd3125;
	localparam logic [WordW-1:0] DenBias    = 32'd32768;
	localparam logic [WordW-1:0] TempRound  = 32'd128;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TEMP    = 8'd0,
		CFG_PRESS_A = 8'd1,
		CFG_PRESS_B = 8'd2,
		CFG_PRESS_C = 8'd3
	} cfg_idx_t;

	// sign-extend a 16-bit coefficient to a word
	function automatic logic [WordW-1:0] sx16(input logic [CoefW-1:0] v);
		sx16 = {{(WordW-CoefW){v[CoefW-1]}}, v};
	endfunction

	// arithmetic right shift of a word
	function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v, input int s);
		asr = WordW'($signed(v) >>> s);
	endfunction

endpackage

FILE: design/psc_in_if.sv
interface psc_in_if import psc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [RawW-1:0] raw_temp;
	logic [RawW-1:0] raw_press;

	modport source (output valid, raw_temp, raw_press, input ready);
	modport sink (input valid, raw_temp, raw_press, output ready);
endinterface

FILE: design/psc_out_if.sv
interface psc_out_if import psc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [TempW-1:0] temp_centi;
	logic [WordW-1:0]  pressure_pa;
	logic              pressure_valid;

	modport source (output valid, temp_centi, pressure_pa, pressure_valid, input ready);
	modport sink (input valid, temp_centi, pressure_pa, pressure_valid, output ready);
endinterface

FILE: design/psc_cfg_if.sv
interface psc_cfg_if import psc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pressure_temp_sensor_compensation.sv
// Barometric sensor compensation, 32-bit integer formulas.
//
// Channels: in_ch carries one raw temperature and one raw pressure reading
// per item; out_ch returns the temperature in hundredths of a degree, the
// pressure in pascals and a flag that is low when the pressure denominator
// was zero (pressure then reads 0). cfg writes the four calibration
// registers by index; it is always ready and an unknown index is dropped.
// Write calibration only while no item is in flight.
//
// Throughput: one item per cycle while the output is not stalled. The path
// from acceptance to out_ch.valid runs through 9 stages of multiply/add, a
// 32-stage restoring divider that resolves one quotient bit per stage, and 3 correction stages.
//
// Reset clears every stage valid bit and all calibration registers.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops
// unless the output stage is empty; nothing is lost or repeated.
module pressure_temp_sensor_compensation import psc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	psc_in_if.sink    in_ch,
	psc_out_if.source out_ch,
	psc_cfg_if.sink   cfg
);

	localparam int DivN = WordW;

	logic [47:0] temp_cal_q;
	logic [63:0] press_cal_a_q;
	logic [63:0] press_cal_b_q;
	logic [15:0] press_cal_c_q;

	logic [WordW-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

	// calibration register writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_TEMP:    temp_cal_q    <= cfg.data[47:0];
				CFG_PRESS_A: press_cal_a_q <= cfg.data;
				CFG_PRESS_B: press_cal_b_q <= cfg.data;
				CFG_PRESS_C: press_cal_c_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	assign t1 = {16'd0, temp_cal_q[15:0]};
	assign t2 = sx16(temp_cal_q[31:16]);
	assign t3 = sx16(temp_cal_q[47:32]);
	assign p1 = {16'd0, press_cal_a_q[15:0]};
	assign p2 = sx16(press_cal_a_q[31:16]);
	assign p3 = sx16(press_cal_a_q[47:32]);
	assign p4 = sx16(press_cal_a_q[63:48]);
	assign p5 = sx16(press_cal_b_q[15:0]);
	assign p6 = sx16(press_cal_b_q[31:16]);
	assign p7 = sx16(press_cal_b_q[47:32]);
	assign p8 = sx16(press_cal_b_q[63:48]);
	assign p9 = sx16(press_cal_c_q);

	// global advance: move when the output stage is empty or being taken
	logic en;
	logic v_s12;
	assign en          = !v_s12 || out_ch.ready;
	assign in_ch.ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [DivN-1:0] dv_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
			dv_v_s <= '0;
		end else if (en) begin
			v_s1   <= in_ch.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			dv_v_s <= {dv_v_s[DivN-2:0], v_s9};
			v_s10  <= dv_v_s[DivN-1];
			v_s11  <= v_s10;
			v_s12  <= v_s11;
		end
	end

	// temperature and pressure-coefficient stages
	logic [WordW-1:0] ta, td;
	logic [WordW-1:0] m1_s1, dd_s1;
	logic [RawW-1:0]  ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7;
	logic [WordW-1:0] v1t_s2, m2_s2;
	logic [WordW-1:0] fine_s3;
	logic [WordW-1:0] v1p_s4;
	logic [TempW-1:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11;
	logic [WordW-1:0] q_s4;
	logic [WordW-1:0] qq_s5, m5_s5, m2p_s5, m5_s6, m2p_s6;
	logic [WordW-1:0] v2a_s6, m3_s6;
	logic [WordW-1:0] v2_s7, v1x_s7;
	logic [WordW-1:0] den_s8, num_s8, den_s9;
	logic [WordW-1:0] pm_s9;
	logic [WordW-1:0] fine5;

	assign ta    = {15'd0, in_ch.raw_temp[RawW-1:3]} - {t1[WordW-2:0], 1'b0};
	assign td    = {16'd0, in_ch.raw_temp[RawW-1:4]} - t1;
	assign fine5 = (fine_s3 << 2) + fine_s3 + TempRound;
	assign q_s4  = asr(v1p_s4, 2);

	always_ff @(posedge clk) begin
		if (en) begin
			// products of the temperature offsets
			m1_s1  <= ta * t2;
			dd_s1  <= td * td;
			ap_s1  <= in_ch.raw_press;
			// scale
			v1t_s2 <= asr(m1_s1, 11);
			m2_s2  <= asr(dd_s1, 12) * t3;
			ap_s2  <= ap_s1;
			// fine temperature
			fine_s3 <= v1t_s2 + asr(m2_s2, 14);
			ap_s3   <= ap_s2;
			// temperature result and pressure offset
			v1p_s4 <= asr(fine_s3, 1) - TempOfs;
			tc_s4  <= fine5[8 +: TempW];
			ap_s4  <= ap_s3;
			// square and linear pressure products
			qq_s5  <= q_s4 * q_s4;
			m5_s5  <= v1p_s4 * p5;
			m2p_s5 <= p2 * v1p_s4;
			tc_s5  <= tc_s4;
			ap_s5  <= ap_s4;
			// quadratic pressure products
			v2a_s6 <= asr(qq_s5, 11) * p6;
			m3_s6  <= p3 * asr(qq_s5, 13);
			m5_s6  <= m5_s5;
			m2p_s6 <= m2p_s5;
			tc_s6  <= tc_s5;
			ap_s6  <= ap_s5;
			// combine into var2 and var1
			v2_s7  <= asr(v2a_s6 + (m5_s6 << 1), 2) + (p4 << 16);
			v1x_s7 <= asr(asr(m3_s6, 3) + asr(m2p_s6, 1), 18);
			tc_s7  <= tc_s6;
			ap_s7  <= ap_s6;
			// denominator and numerator
			den_s8 <= asr((DenBias + v1x_s7) * p1, 15);
			num_s8 <= (PressBase - {12'd0, ap_s7}) - asr(v2_s7, 12);
			tc_s8  <= tc_s7;
			// scale numerator
			pm_s9  <= num_s8 * PressScale;
			den_s9 <= den_s8;
			tc_s9  <= tc_s8;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [WordW-1:0] dv_rem_s [DivN];
	logic [WordW-1:0] dv_quo_s [DivN];
	logic [WordW-1:0] dv_den_s [DivN];
	logic [DivN-1:0]  dv_post_s;
	logic [TempW-1:0] dv_tc_s  [DivN];

	genvar k;
	generate
		for (k = 0; k < DivN; k++) begin : g_div
			logic [WordW-1:0] rem_in, quo_in, den_in;
			logic             post_in;
			logic [TempW-1:0] tc_in;
			logic [WordW:0]   r;
			logic             ge;
			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign quo_in  = pm_s9[WordW-1] ? pm_s9 : {pm_s9[WordW-2:0], 1'b0};
				assign post_in = pm_s9[WordW-1];
				assign den_in  = den_s9;
				assign tc_in   = tc_s9;
			end else begin : g_next
				assign rem_in  = dv_rem_s[k-1];
				assign quo_in  = dv_quo_s[k-1];
				assign post_in = dv_post_s[k-1];
				assign den_in  = dv_den_s[k-1];
				assign tc_in   = dv_tc_s[k-1];
			end
			assign r  = {rem_in, quo_in[WordW-1]};
			assign ge = r >= {1'b0, den_in};
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k]  <= ge ? WordW'(r - {1'b0, den_in}) : r[WordW-1:0];
					dv_quo_s[k]  <= {quo_in[WordW-2:0], ge};
					dv_den_s[k]  <= den_in;
					dv_post_s[k] <= post_in;
					dv_tc_s[k]   <= tc_in;
				end
			end
		end
	endgenerate

	// correction stages
	logic [WordW-1:0] pd, pq;
	logic [WordW-1:0] p_s10, qq2_s10, m8_s10, p_s11, w1_s11, w2_s11;
	logic             ok_s10, ok_s11;
	logic [TempW-1:0] tc_s12;
	logic [WordW-1:0] p_s12;
	logic             ok_s12;

	assign pd = dv_post_s[DivN-1] ? {dv_quo_s[DivN-1][WordW-2:0], 1'b0} : dv_quo_s[DivN-1];
	assign pq = pd >> 3;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s10   <= pd;
			qq2_s10 <= pq * pq;
			m8_s10  <= (pd >> 2) * p8;
			ok_s10  <= dv_den_s[DivN-1] != '0;
			tc_s10  <= dv_tc_s[DivN-1];
			// second-order terms
			w1_s11  <= asr(p9 * (qq2_s10 >> 13), 12);
			w2_s11  <= asr(m8_s10, 13);
			p_s11   <= p_s10;
			ok_s11  <= ok_s10;
			tc_s11  <= tc_s10;
			// final pressure, zero on a null denominator
			p_s12   <= ok_s11 ? p_s11 + asr(w1_s11 + w2_s11 + p7, 4) : '0;
			ok_s12  <= ok_s11;
			tc_s12  <= tc_s11;
		end
	end

	assign out_ch.valid          = v_s12;
	assign out_ch.temp_centi     = tc_s12;
	assign out_ch.pressure_pa    = p_s12;
	assign out_ch.pressure_valid = ok_s12;

	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 && !ok_s12 |-> p_s12 == '0) else $error("invalid item with nonzero pressure");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1) else $error("accepted item not in first stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(fine_s3) && $stable(dv_v_s)) else $error("pipeline moved while stalled");

endmodule
